>>> hw/rtl/cbc_pkg.sv
package cbc_pkg;

    // Table geometry. The cell count is a power of two, so the cell wrap is a mask.
    localparam int NUM_CELLS               = 1024;
    localparam int NUM_CHIPS               = 4;
    localparam int TABLE_CHANNELS_PER_CHIP = 9;
    localparam int SIGNAL_CHANNELS         = 8;
    localparam int TABLE_ROW               = NUM_CHIPS * TABLE_CHANNELS_PER_CHIP;
    localparam int TABLE_SIZE              = NUM_CELLS * TABLE_ROW;

    // Field widths.
    localparam int CHIP_W   = 2;
    localparam int CHAN_W   = 4;
    localparam int POS_W    = 10;
    localparam int VAL_W    = 13;
    localparam int CORR_W   = 14;
    localparam int OUT_CH_W = 5;
    localparam int CELL_W   = $clog2(NUM_CELLS);
    localparam int ADDR_W   = $clog2(TABLE_SIZE);

    // Operation codes.
    typedef enum logic [0:0] {
        OP_LOAD    = 1'b0,
        OP_CORRECT = 1'b1
    } t_op;

    // Sample data that travels alongside the table read.
    typedef struct packed {
        logic [OUT_CH_W-1:0]    channel;
        logic [POS_W-1:0]       sample;
        logic signed [VAL_W-1:0] value;
    } t_meta;

    // Table access request from the front end to the back end.
    typedef struct packed {
        logic  rd_valid;
        t_meta meta;
    } t_req;

endpackage

>>> hw/rtl/cbc_ram.sv
module cbc_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 36864
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; the read data holds while
    // the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/cbc_front.sv
module cbc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_en_read,
    input  logic                          i_operation,
    input  logic [cbc_pkg::CHIP_W-1:0]    i_chip,
    input  logic [cbc_pkg::CHAN_W-1:0]    i_chip_channel,
    input  logic [cbc_pkg::POS_W-1:0]     i_position,
    input  logic [cbc_pkg::POS_W-1:0]     i_trigger_cell,
    input  logic signed [cbc_pkg::VAL_W-1:0] i_value,
    output logic                          o_ready,
    output logic                          o_we,
    output logic [cbc_pkg::ADDR_W-1:0]    o_addr,
    output logic [cbc_pkg::VAL_W-1:0]     o_wdata,
    output cbc_pkg::t_req                 o_req
);

    import cbc_pkg::*;

    logic                en_a;
    logic                en_b;
    logic                chip_ok;
    logic                load_ok;
    logic                corr_ok;
    logic [POS_W:0]      cell_sum;
    logic [CELL_W-1:0]   n_a_cell;
    t_meta               n_a_meta;
    logic [ADDR_W-1:0]   n_b_addr;

    logic                r_a_v;
    logic                r_a_wr;
    logic [CELL_W-1:0]   r_a_cell;
    logic [CHIP_W-1:0]   r_a_chip;
    logic [CHAN_W-1:0]   r_a_chan;
    t_meta               r_a_meta;

    logic                r_b_v;
    logic                r_b_wr;
    logic [ADDR_W-1:0]   r_b_addr;
    t_meta               r_b_meta;

    // A stage moves on when it is empty or the stage after it moves.
    assign en_b    = !r_b_v || i_en_read;
    assign en_a    = !r_a_v || en_b;
    assign o_ready = en_a;

    // Decode: drop loads outside the table, and samples outside the table or the signal channels.
    always_comb begin
        chip_ok  = 32'(i_chip) < NUM_CHIPS;
        load_ok  = chip_ok && (t_op'(i_operation) == OP_LOAD)
                   && (32'(i_chip_channel) < TABLE_CHANNELS_PER_CHIP);
        corr_ok  = chip_ok && (t_op'(i_operation) == OP_CORRECT)
                   && (32'(i_chip_channel) < SIGNAL_CHANNELS)
                   && (32'(i_chip_channel) < TABLE_CHANNELS_PER_CHIP);
        cell_sum = {1'b0, i_trigger_cell} + {1'b0, i_position};
        if (t_op'(i_operation) == OP_CORRECT) begin
            n_a_cell = cell_sum[CELL_W-1:0];
        end else begin
            n_a_cell = i_position[CELL_W-1:0];
        end
        n_a_meta.channel = OUT_CH_W'(32'(i_chip) * SIGNAL_CHANNELS + 32'(i_chip_channel));
        n_a_meta.sample  = i_position;
        n_a_meta.value   = i_value;
    end

    // Stage A: decoded item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en_a) begin
            r_a_v <= i_accept && (load_ok || corr_ok);
        end
        if (en_a) begin
            r_a_wr   <= load_ok;
            r_a_cell <= n_a_cell;
            r_a_chip <= i_chip;
            r_a_chan <= i_chip_channel;
            r_a_meta <= n_a_meta;
        end
    end

    // Table address of the cell row plus the chip and channel column.
    assign n_b_addr = ADDR_W'(r_a_cell) * ADDR_W'(TABLE_ROW)
                    + ADDR_W'(r_a_chip) * ADDR_W'(TABLE_CHANNELS_PER_CHIP)
                    + ADDR_W'(r_a_chan);

    // Stage B: table address, presented to the memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en_b) begin
            r_b_v <= r_a_v;
        end
        if (en_b) begin
            r_b_wr   <= r_a_wr;
            r_b_addr <= n_b_addr;
            r_b_meta <= r_a_meta;
        end
    end

    // Loads write the table as they leave stage B; samples read it.
    assign o_we          = r_b_v && r_b_wr && i_en_read;
    assign o_addr        = r_b_addr;
    assign o_wdata       = r_b_meta.value;
    assign o_req.rd_valid = r_b_v && !r_b_wr;
    assign o_req.meta     = r_b_meta;

endmodule

>>> hw/rtl/cbc_back.sv
module cbc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cbc_pkg::t_req                     i_req,
    input  logic [cbc_pkg::VAL_W-1:0]         i_rdata,
    input  logic                              i_stall,
    output logic                              o_en_read,
    output logic                              o_valid,
    output logic signed [cbc_pkg::CORR_W-1:0] o_corrected,
    output logic [cbc_pkg::OUT_CH_W-1:0]      o_out_channel,
    output logic [cbc_pkg::POS_W-1:0]         o_out_sample
);

    import cbc_pkg::*;

    logic               en_c;
    logic               en_d;

    logic               r_c_v;
    t_meta              r_c_meta;

    logic               r_d_v;
    logic [CORR_W-1:0]  r_d_corr;
    logic [OUT_CH_W-1:0] r_d_channel;
    logic [POS_W-1:0]   r_d_sample;

    assign en_d      = !r_d_v || !i_stall;
    assign en_c      = !r_c_v || en_d;
    assign o_en_read = en_c;

    // Stage C: sample data waits here while the baseline comes out of the memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en_c) begin
            r_c_v <= i_req.rd_valid;
        end
        if (en_c) begin
            r_c_meta <= i_req.meta;
        end
    end

    // Stage D: output register holding raw minus baseline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en_d) begin
            r_d_v <= r_c_v;
        end
        if (en_d) begin
            r_d_corr    <= {r_c_meta.value[VAL_W-1], r_c_meta.value}
                         - {i_rdata[VAL_W-1], i_rdata};
            r_d_channel <= r_c_meta.channel;
            r_d_sample  <= r_c_meta.sample;
        end
    end

    assign o_valid       = r_d_v;
    assign o_corrected   = r_d_corr;
    assign o_out_channel = r_d_channel;
    assign o_out_sample  = r_d_sample;

endmodule

>>> hw/rtl/cell_baseline_correction.sv
// Per-cell baseline correction for a four-chip switched-capacitor digitizer.
// Stages: A decodes, B forms the address, C waits on the table read, D subtracts.
// Throughput: one item per cycle while i_stall is low; the baseline table is
// single-write, single-read, touched once per item; loads and samples mix freely.
// Reset (synchronous, active low) empties the pipeline; the table is not cleared.
module cell_baseline_correction (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_operation,
    input  logic [cbc_pkg::CHIP_W-1:0]        i_chip,
    input  logic [cbc_pkg::CHAN_W-1:0]        i_chip_channel,
    input  logic [cbc_pkg::POS_W-1:0]         i_position,
    input  logic [cbc_pkg::POS_W-1:0]         i_trigger_cell,
    input  logic signed [cbc_pkg::VAL_W-1:0]  i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [cbc_pkg::CORR_W-1:0] o_corrected,
    output logic [cbc_pkg::OUT_CH_W-1:0]      o_out_channel,
    output logic [cbc_pkg::POS_W-1:0]         o_out_sample
);

    import cbc_pkg::*;

    logic              ready;
    logic              accept;
    logic              en_read;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  wdata;
    logic [VAL_W-1:0]  rdata;
    t_req              req;

    assign o_stall = !ready;
    assign accept  = i_valid && ready;

    // Decode and address generation.
    cbc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_en_read      (en_read),
        .i_operation    (i_operation),
        .i_chip         (i_chip),
        .i_chip_channel (i_chip_channel),
        .i_position     (i_position),
        .i_trigger_cell (i_trigger_cell),
        .i_value        (i_value),
        .o_ready        (ready),
        .o_we           (we),
        .o_addr         (addr),
        .o_wdata        (wdata),
        .o_req          (req)
    );

    // Baseline table.
    cbc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr),
        .i_wdata (wdata),
        .i_re    (en_read),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    // Subtract and output register.
    cbc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .i_rdata       (rdata),
        .i_stall       (i_stall),
        .o_en_read     (en_read),
        .o_valid       (o_valid),
        .o_corrected   (o_corrected),
        .o_out_channel (o_out_channel),
        .o_out_sample  (o_out_sample)
    );

endmodule
